/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the segment projection checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define WSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/wsp_pkg.sv */
// ----------------------------------------------------------------------------
// wsp_pkg
// Types, widths and constants of the wall segment projection pipeline.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int CFG_W = 32;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_CAMERA_POS_X  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_CAMERA_POS_Y  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ROT_COSINE    = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_ROT_SINE      = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_VIEW_DISTANCE = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = IDX_W'(5);

  localparam logic signed [15:0] RST_COSINE   = 16'sd16384;
  localparam logic signed [15:0] RST_SINE     = 16'sd0;
  localparam logic [11:0]        RST_VIEW     = 12'd320;
  localparam logic [11:0]        RST_WIDTH    = 12'd640;

  // camera-space coordinate width: (33b x 16b products, summed) >> 14
  localparam int ZW = 36;
  localparam int NEAR_Q16 = 6554;
  localparam logic signed [ZW-1:0] NEAR_Z = ZW'(NEAR_Q16);

  // clip fraction divider: ((near - za) << 16) / (zb - za)
  localparam int CLIP_QW = 16;
  localparam int CLIP_DW = ZW + 1;
  localparam int CLIP_NW = ZW + 1 + CLIP_QW;

  // projection divider: |lat * view_distance| / depth
  localparam int PW      = ZW + 12;
  localparam int PROJ_QW = 17;

  localparam logic signed [15:0] X_MAX = 16'sh7FFF;
  localparam logic signed [15:0] X_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } seg_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] left_screen_x;
    logic signed [15:0] right_screen_x;
    logic [30:0]        left_depth;
    logic [30:0]        right_depth;
  } result_t;

  // rotated endpoints plus clip decision
  typedef struct packed {
    logic               invis;
    logic               clip1;
    logic               clip2;
    logic signed [ZW-1:0] z1;
    logic signed [ZW-1:0] l1;
    logic signed [ZW-1:0] z2;
    logic signed [ZW-1:0] l2;
    logic signed [ZW:0]   diff;
  } geom_t;

  typedef struct packed {
    logic          neg;
    logic [PW-1:0] mag;
    logic [ZW-1:0] depth;
  } proj_t;

  typedef struct packed {
    logic          neg;
    logic [ZW-1:0] depth;
  } lane_side_t;

  typedef struct packed {
    logic       invis;
    lane_side_t lane;
  } left_side_t;

endpackage

/* sv/wsp_div.sv */
// ----------------------------------------------------------------------------
// wsp_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module wsp_div #(
  parameter int NW = wsp_pkg::CLIP_NW,
  parameter int DW = wsp_pkg::CLIP_DW,
  parameter int QW = wsp_pkg::CLIP_QW,
  parameter int SW = $bits(wsp_pkg::geom_t)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic          overflow,
  output logic [SW-1:0] side_out
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld [0:QW];
  logic          ovf [0:QW];
  logic [QW-1:0] quo [0:QW];
  logic [SW-1:0] sd  [0:QW];
  logic [RW-1:0] rem [0:QW-1];
  logic [DW-1:0] den [0:QW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  // quotient must fit QW bits, else flag it
  always_ff @(posedge clk) begin
    rem[0] <= RW'(dividend);
    den[0] <= divisor;
    quo[0] <= '0;
    ovf[0] <= RW'(dividend) >= (RW'(divisor) << QW);
    sd[0]  <= side_in;
  end

  genvar k;
  for (k = 0; k < QW; k++) begin : g_step
    localparam int SH = QW - 1 - k;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = RW'(den[k]) << SH;
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      quo[k+1] <= quo[k] | (QW'(take) << SH);
      ovf[k+1] <= ovf[k];
      sd[k+1]  <= sd[k];
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[k+1] <= take ? rem[k] - trial : rem[k];
        den[k+1] <= den[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = quo[QW];
  assign overflow  = ovf[QW];
  assign side_out  = sd[QW];

endmodule

/* sv/wsp_xform.sv */
// ----------------------------------------------------------------------------
// wsp_xform
// Camera offset, rotation into camera space and near-plane clip setup.
// ----------------------------------------------------------------------------
module wsp_xform (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  wsp_pkg::seg_t                   seg,
  input  logic signed [31:0]              camera_pos_x,
  input  logic signed [31:0]              camera_pos_y,
  input  logic signed [15:0]              rot_cosine,
  input  logic signed [15:0]              rot_sine,
  output logic                            out_valid,
  output wsp_pkg::geom_t                  geom,
  output logic [wsp_pkg::CLIP_NW-1:0]     num,
  output logic [wsp_pkg::CLIP_DW-1:0]     den
);

  localparam int ZW = wsp_pkg::ZW;

  logic v1, v2, v3;

  // stage 1: offsets
  logic signed [32:0] dx1, dy1, dx2, dy2;
  // stage 2: products
  logic signed [48:0] xc1, ys1, yc1, xs1, xc2, ys2, yc2, xs2;
  // stage 3: rotated coordinates
  logic signed [ZW-1:0] z1, l1, z2, l2;
  logic signed [49:0] sz1, sl1, sz2, sl2;
  // stage 4 combinational
  logic invis, clip1, clip2;
  logic signed [ZW-1:0] za, zb, la, lb;
  logic signed [ZW:0]   gap, span, diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    dx1 <= $signed({seg.start_x[31], seg.start_x}) - $signed({camera_pos_x[31], camera_pos_x});
    dy1 <= $signed({seg.start_y[31], seg.start_y}) - $signed({camera_pos_y[31], camera_pos_y});
    dx2 <= $signed({seg.end_x[31], seg.end_x}) - $signed({camera_pos_x[31], camera_pos_x});
    dy2 <= $signed({seg.end_y[31], seg.end_y}) - $signed({camera_pos_y[31], camera_pos_y});
  end

  always_ff @(posedge clk) begin
    xc1 <= dx1 * rot_cosine;
    ys1 <= dy1 * rot_sine;
    yc1 <= dy1 * rot_cosine;
    xs1 <= dx1 * rot_sine;
    xc2 <= dx2 * rot_cosine;
    ys2 <= dy2 * rot_sine;
    yc2 <= dy2 * rot_cosine;
    xs2 <= dx2 * rot_sine;
  end

  // arithmetic shift gives the floor
  assign sz1 = 50'(xc1) + 50'(ys1);
  assign sl1 = 50'(yc1) - 50'(xs1);
  assign sz2 = 50'(xc2) + 50'(ys2);
  assign sl2 = 50'(yc2) - 50'(xs2);

  always_ff @(posedge clk) begin
    z1 <= ZW'(sz1 >>> 14);
    l1 <= ZW'(sl1 >>> 14);
    z2 <= ZW'(sz2 >>> 14);
    l2 <= ZW'(sl2 >>> 14);
  end

  // a depth exactly on the plane is not clipped, but a segment with no endpoint beyond it is invisible
  always_comb begin
    invis = (z1 <= wsp_pkg::NEAR_Z) && (z2 <= wsp_pkg::NEAR_Z);
    clip1 = !invis && (z1 < wsp_pkg::NEAR_Z);
    clip2 = !invis && !clip1 && (z2 < wsp_pkg::NEAR_Z);
    za    = clip1 ? z1 : z2;
    zb    = clip1 ? z2 : z1;
    la    = clip1 ? l1 : l2;
    lb    = clip1 ? l2 : l1;
    gap   = (ZW+1)'(wsp_pkg::NEAR_Z) - (ZW+1)'(za);
    span  = (ZW+1)'(zb) - (ZW+1)'(za);
    diff  = (ZW+1)'(lb) - (ZW+1)'(la);
  end

  always_ff @(posedge clk) begin
    geom.invis <= invis;
    geom.clip1 <= clip1;
    geom.clip2 <= clip2;
    geom.z1    <= z1;
    geom.l1    <= l1;
    geom.z2    <= z2;
    geom.l2    <= l2;
    geom.diff  <= diff;
    if (clip1 || clip2) begin
      num <= {gap, {wsp_pkg::CLIP_QW{1'b0}}};
      den <= span;
    end else begin
      num <= '0;
      den <= wsp_pkg::CLIP_DW'(1);
    end
  end

endmodule

/* sv/wsp_interp.sv */
// ----------------------------------------------------------------------------
// wsp_interp
// Clip interpolation, lateral times view distance, sign and magnitude split.
// ----------------------------------------------------------------------------
module wsp_interp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [wsp_pkg::CLIP_QW-1:0]   t_raw,
  input  logic                          t_ovf,
  input  wsp_pkg::geom_t                geom,
  input  logic [11:0]                   view_distance,
  output logic                          out_valid,
  output logic                          invis,
  output wsp_pkg::proj_t                lane1,
  output wsp_pkg::proj_t                lane2
);

  localparam int ZW = wsp_pkg::ZW;
  localparam int PW = wsp_pkg::PW;
  localparam int MW = ZW + 1 + wsp_pkg::CLIP_QW + 1;
  localparam int AW = ZW + 2;

  logic v5, v6, v7;

  logic [wsp_pkg::CLIP_QW-1:0] t_val;
  logic signed [MW-1:0] prod;
  wsp_pkg::geom_t       g5;

  logic signed [MW-1:0] adj;
  logic signed [AW-1:0] moved;

  logic signed [ZW-1:0] lat1, lat2, dep1, dep2;
  logic                 inv6, inv7;
  logic signed [PW-1:0] m1, m2;
  logic signed [ZW-1:0] d71, d72;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v5 <= in_valid;
      v6 <= v5;
      v7 <= v6;
      out_valid <= v7;
    end
  end

  assign t_val = t_ovf ? '1 : t_raw;

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, t_val}) * geom.diff;
    g5   <= geom;
  end

  // the clipped endpoint moves toward the other one
  always_comb begin
    adj   = prod >>> wsp_pkg::CLIP_QW;
    moved = AW'(g5.clip1 ? g5.l1 : g5.l2) + AW'(adj);
  end

  always_ff @(posedge clk) begin
    lat1 <= g5.clip1 ? ZW'(moved) : g5.l1;
    lat2 <= g5.clip2 ? ZW'(moved) : g5.l2;
    dep1 <= g5.clip1 ? wsp_pkg::NEAR_Z : g5.z1;
    dep2 <= g5.clip2 ? wsp_pkg::NEAR_Z : g5.z2;
    inv6 <= g5.invis;
  end

  always_ff @(posedge clk) begin
    m1   <= lat1 * $signed({1'b0, view_distance});
    m2   <= lat2 * $signed({1'b0, view_distance});
    d71  <= dep1;
    d72  <= dep2;
    inv7 <= inv6;
  end

  always_ff @(posedge clk) begin
    lane1.neg   <= m1[PW-1];
    lane1.mag   <= m1[PW-1] ? PW'(-m1) : PW'(m1);
    lane1.depth <= d71;
    lane2.neg   <= m2[PW-1];
    lane2.mag   <= m2[PW-1] ? PW'(-m2) : PW'(m2);
    lane2.depth <= d72;
    invis       <= inv7;
  end

endmodule

/* sv/wall_segment_screen_projection.sv */
// ----------------------------------------------------------------------------
// wall_segment_screen_projection
// Projects one 2D wall segment to a pair of screen columns with depths.
// ----------------------------------------------------------------------------
// Fully pipelined: a segment transaction is taken in every cycle in which
// start is high (busy is only high during reset), and its result is strobed
// on done in order, one result per segment. The pipeline is made of the two
// bit-serial divider chains: 17 stages for the near-plane clip fraction and
// 18 for the perspective divide, plus ten stages of offset, rotate,
// interpolate, scale and ordering logic. There is no back-pressure:
// done/result last one cycle and must be captured then. Configuration
// writes take effect at once and must be made with the pipeline empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wall_segment_screen_projection (
  input  logic                          clk,
  input  logic                          rst,
  // segment transactions
  input  logic                          start,
  output logic                          busy,
  input  wsp_pkg::seg_t                 seg,
  // result transactions
  output logic                          done,
  output wsp_pkg::result_t              result,
  // register writes
  input  logic                          cfg_write,
  input  logic [wsp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [wsp_pkg::CFG_W-1:0]     cfg_data
);

  localparam int ZW  = wsp_pkg::ZW;
  localparam int QX  = wsp_pkg::PROJ_QW;
  localparam int SWL = $bits(wsp_pkg::left_side_t);
  localparam int SWR = $bits(wsp_pkg::lane_side_t);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] camera_pos_x, camera_pos_y;
  logic signed [15:0] rot_cosine, rot_sine;
  logic [11:0]        view_distance, screen_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_pos_x  <= '0;
      camera_pos_y  <= '0;
      rot_cosine    <= wsp_pkg::RST_COSINE;
      rot_sine      <= wsp_pkg::RST_SINE;
      view_distance <= wsp_pkg::RST_VIEW;
      screen_width  <= wsp_pkg::RST_WIDTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wsp_pkg::REG_CAMERA_POS_X:  camera_pos_x  <= cfg_data;
        wsp_pkg::REG_CAMERA_POS_Y:  camera_pos_y  <= cfg_data;
        wsp_pkg::REG_ROT_COSINE:    rot_cosine    <= cfg_data[15:0];
        wsp_pkg::REG_ROT_SINE:      rot_sine      <= cfg_data[15:0];
        wsp_pkg::REG_VIEW_DISTANCE: view_distance <= cfg_data[11:0];
        wsp_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[11:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // accept whenever not in reset
  assign busy = rst;

  // --------------------------------------------------------------------------
  // Stages 1-4: camera space and clip setup
  // --------------------------------------------------------------------------
  logic                             xf_valid;
  wsp_pkg::geom_t                   xf_geom;
  logic [wsp_pkg::CLIP_NW-1:0]      xf_num;
  logic [wsp_pkg::CLIP_DW-1:0]      xf_den;

  wsp_xform u_xform (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .seg          (seg),
    .camera_pos_x (camera_pos_x),
    .camera_pos_y (camera_pos_y),
    .rot_cosine   (rot_cosine),
    .rot_sine     (rot_sine),
    .out_valid    (xf_valid),
    .geom         (xf_geom),
    .num          (xf_num),
    .den          (xf_den)
  );

  // --------------------------------------------------------------------------
  // Clip fraction t in Q0.16 (17 stages)
  // --------------------------------------------------------------------------
  logic                          cd_valid, cd_ovf;
  logic [wsp_pkg::CLIP_QW-1:0]   cd_t;
  logic [$bits(wsp_pkg::geom_t)-1:0] cd_side;
  wsp_pkg::geom_t                cd_geom;

  wsp_div #(
    .NW (wsp_pkg::CLIP_NW),
    .DW (wsp_pkg::CLIP_DW),
    .QW (wsp_pkg::CLIP_QW),
    .SW ($bits(wsp_pkg::geom_t))
  ) u_clip_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xf_valid),
    .dividend  (xf_num),
    .divisor   (xf_den),
    .side_in   (xf_geom),
    .out_valid (cd_valid),
    .quotient  (cd_t),
    .overflow  (cd_ovf),
    .side_out  (cd_side)
  );

  assign cd_geom = cd_side;

  // --------------------------------------------------------------------------
  // Interpolation and scale by view distance
  // --------------------------------------------------------------------------
  logic           ip_valid, ip_invis;
  wsp_pkg::proj_t ip_lane1, ip_lane2;

  wsp_interp u_interp (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (cd_valid),
    .t_raw         (cd_t),
    .t_ovf         (cd_ovf),
    .geom          (cd_geom),
    .view_distance (view_distance),
    .out_valid     (ip_valid),
    .invis         (ip_invis),
    .lane1         (ip_lane1),
    .lane2         (ip_lane2)
  );

  // --------------------------------------------------------------------------
  // Perspective divide, one lane per endpoint (18 stages each)
  // --------------------------------------------------------------------------
  wsp_pkg::left_side_t ls_in, ls_out;
  wsp_pkg::lane_side_t rs_in, rs_out;
  logic [SWL-1:0]      ls_vec;
  logic [SWR-1:0]      rs_vec;
  logic                pl_valid, pr_valid, pl_ovf, pr_ovf;
  logic [QX-1:0]       pl_q, pr_q;

  assign ls_in.invis      = ip_invis;
  assign ls_in.lane.neg   = ip_lane1.neg;
  assign ls_in.lane.depth = ip_lane1.depth;
  assign rs_in.neg        = ip_lane2.neg;
  assign rs_in.depth      = ip_lane2.depth;

  wsp_div #(
    .NW (wsp_pkg::PW),
    .DW (ZW),
    .QW (QX),
    .SW (SWL)
  ) u_proj_div_l (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ip_valid),
    .dividend  (ip_lane1.mag),
    .divisor   (ip_lane1.depth),
    .side_in   (ls_in),
    .out_valid (pl_valid),
    .quotient  (pl_q),
    .overflow  (pl_ovf),
    .side_out  (ls_vec)
  );

  wsp_div #(
    .NW (wsp_pkg::PW),
    .DW (ZW),
    .QW (QX),
    .SW (SWR)
  ) u_proj_div_r (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ip_valid),
    .dividend  (ip_lane2.mag),
    .divisor   (ip_lane2.depth),
    .side_in   (rs_in),
    .out_valid (pr_valid),
    .quotient  (pr_q),
    .overflow  (pr_ovf),
    .side_out  (rs_vec)
  );

  assign ls_out = ls_vec;
  assign rs_out = rs_vec;

  // --------------------------------------------------------------------------
  // Stage 44: signed quotient, center offset, 16-bit saturation.
  // A quotient of 2^17 or more saturates whatever the center.
  // --------------------------------------------------------------------------
  function automatic logic signed [15:0] col_sat(
    input logic          ovf,
    input logic          neg,
    input logic [QX-1:0] q,
    input logic [11:0]   sw
  );
    logic signed [QX+1:0] qs;
    logic signed [QX+1:0] s;
    qs = neg ? -$signed((QX+2)'(q)) : $signed((QX+2)'(q));
    s  = qs + $signed((QX+2)'(sw[11:1]));
    if (ovf) begin
      col_sat = neg ? wsp_pkg::X_MIN : wsp_pkg::X_MAX;
    end else if (s > wsp_pkg::X_MAX) begin
      col_sat = wsp_pkg::X_MAX;
    end else if (s < wsp_pkg::X_MIN) begin
      col_sat = wsp_pkg::X_MIN;
    end else begin
      col_sat = 16'(s);
    end
  endfunction

  function automatic logic [30:0] depth_sat(input logic [ZW-1:0] d);
    depth_sat = (d[ZW-1:31] != '0) ? '1 : d[30:0];
  endfunction

  logic               s9_valid, s9_invis;
  logic signed [15:0] x1, x2;
  logic [ZW-1:0]      d1, d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else begin
      s9_valid <= pl_valid;
    end
  end

  always_ff @(posedge clk) begin
    x1       <= col_sat(pl_ovf, ls_out.lane.neg, pl_q, screen_width);
    x2       <= col_sat(pr_ovf, rs_out.neg, pr_q, screen_width);
    d1       <= ls_out.lane.depth;
    d2       <= rs_out.depth;
    s9_invis <= ls_out.invis;
  end

  // --------------------------------------------------------------------------
  // Stage 45: order left/right (ties keep the first endpoint left), reject
  // invisible segments and those wholly off screen, register the result transaction.
  // --------------------------------------------------------------------------
  logic               swap, reject;
  logic signed [15:0] xl, xr;
  logic [ZW-1:0]      dl, dr;

  always_comb begin
    swap   = x1 > x2;
    xl     = swap ? x2 : x1;
    xr     = swap ? x1 : x2;
    dl     = swap ? d2 : d1;
    dr     = swap ? d1 : d2;
    reject = s9_invis || (xr < 0) || (xl >= $signed({1'b0, screen_width}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (reject) begin
      result <= '0;
    end else begin
      result.visible        <= 1'b1;
      result.left_screen_x  <= xl;
      result.right_screen_x <= xr;
      result.left_depth     <= depth_sat(dl);
      result.right_depth    <= depth_sat(dr);
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  logic hidden_zero, depths_near;

  assign hidden_zero = (result.left_screen_x == '0) && (result.right_screen_x == '0) &&
                       (result.left_depth == '0) && (result.right_depth == '0);
  assign depths_near = (result.left_depth >= 31'(wsp_pkg::NEAR_Q16)) &&
                       (result.right_depth >= 31'(wsp_pkg::NEAR_Q16));

  `WSP_ASSERT_IMPL(a_lanes_lockstep, 1'b1, pl_valid == pr_valid, "divider lanes out of step")
  `WSP_ASSERT_IMPL(a_hidden_zero, done && !result.visible, hidden_zero, "hidden fields nonzero")
  `WSP_ASSERT_IMPL(a_ordered, done && result.visible, xl_le_xr_chk, "columns out of order")
  `WSP_ASSERT_IMPL(a_depth_near, done && result.visible, depths_near, "depth behind near plane")

  logic xl_le_xr_chk;
  assign xl_le_xr_chk = result.left_screen_x <= result.right_screen_x;

endmodule

/* test/wsp_checker.sv */
// ----------------------------------------------------------------------------
// wsp_checker
// Watches segment and result transactions, predicts each result and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wsp_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  wsp_pkg::seg_t             seg,
  input  logic                      done,
  input  wsp_pkg::result_t          result,
  input  logic                      cfg_write,
  input  logic [wsp_pkg::IDX_W-1:0] cfg_index,
  input  logic [wsp_pkg::CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);

  localparam longint NEAR = 6554;

  longint cam_x, cam_y, cos_r, sin_r, vdist, swidth;
  wsp_pkg::result_t proj_q[$];

  function automatic longint fl_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sat_col(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint column(longint lat, longint z);
    return sat_col(swidth / 2 + (lat * vdist) / z);
  endfunction

  function automatic logic [30:0] clamp_depth(longint d);
    if (d > 64'sd2147483647) return 31'h7FFFFFFF;
    if (d < 0) return '0;
    return d[30:0];
  endfunction

  function automatic wsp_pkg::result_t project_segment(wsp_pkg::seg_t s);
    longint dx1, dy1, dx2, dy2, z1, l1, z2, l2, t, x1, x2, tmp;
    wsp_pkg::result_t r;
    r = '0;
    dx1 = longint'(s.start_x) - cam_x;
    dy1 = longint'(s.start_y) - cam_y;
    dx2 = longint'(s.end_x) - cam_x;
    dy2 = longint'(s.end_y) - cam_y;
    z1 = fl_shift(dx1 * cos_r + dy1 * sin_r, 14);
    l1 = fl_shift(dy1 * cos_r - dx1 * sin_r, 14);
    z2 = fl_shift(dx2 * cos_r + dy2 * sin_r, 14);
    l2 = fl_shift(dy2 * cos_r - dx2 * sin_r, 14);
    if (z1 <= NEAR && z2 <= NEAR) return r;
    if (z1 < NEAR) begin
      t = ((NEAR - z1) * 65536) / (z2 - z1);
      l1 = l1 + fl_shift(t * (l2 - l1), 16);
      z1 = NEAR;
    end else if (z2 < NEAR) begin
      t = ((NEAR - z2) * 65536) / (z1 - z2);
      l2 = l2 + fl_shift(t * (l1 - l2), 16);
      z2 = NEAR;
    end
    x1 = column(l1, z1);
    x2 = column(l2, z2);
    if (x1 > x2) begin
      tmp = x1; x1 = x2; x2 = tmp;
      tmp = z1; z1 = z2; z2 = tmp;
    end
    if (x2 < 0 || x1 >= swidth) return r;
    r.visible = 1'b1;
    r.left_screen_x = x1[15:0];
    r.right_screen_x = x2[15:0];
    r.left_depth = clamp_depth(z1);
    r.right_depth = clamp_depth(z2);
    return r;
  endfunction

  assign pending = proj_q.size();

  always @(posedge clk) begin
    wsp_pkg::result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      cam_x <= 0; cam_y <= 0; cos_r <= 16384; sin_r <= 0;
      vdist <= 320; swidth <= 640;
      fail_count <= 0;
      proj_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          wsp_pkg::REG_CAMERA_POS_X:  cam_x <= longint'($signed(cfg_data));
          wsp_pkg::REG_CAMERA_POS_Y:  cam_y <= longint'($signed(cfg_data));
          wsp_pkg::REG_ROT_COSINE:    cos_r <= longint'($signed(cfg_data[15:0]));
          wsp_pkg::REG_ROT_SINE:      sin_r <= longint'($signed(cfg_data[15:0]));
          wsp_pkg::REG_VIEW_DISTANCE: vdist <= longint'(cfg_data[11:0]);
          wsp_pkg::REG_SCREEN_WIDTH:  swidth <= longint'(cfg_data[11:0]);
          default: ;
        endcase
      end
      if (start && !busy) proj_q.push_back(project_segment(seg));
      if (done) begin
        if (proj_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errs++;
        end else begin
          want = proj_q.pop_front();
          if (want.visible !== result.visible) begin
            $error("visible: expected %0d got %0d", want.visible, result.visible);
            errs++;
          end
          if (want.left_screen_x !== result.left_screen_x) begin
            $error("left_screen_x: expected %0d got %0d",
                   want.left_screen_x, result.left_screen_x);
            errs++;
          end
          if (want.right_screen_x !== result.right_screen_x) begin
            $error("right_screen_x: expected %0d got %0d",
                   want.right_screen_x, result.right_screen_x);
            errs++;
          end
          if (want.left_depth !== result.left_depth) begin
            $error("left_depth: expected %0d got %0d",
                   want.left_depth, result.left_depth);
            errs++;
          end
          if (want.right_depth !== result.right_depth) begin
            $error("right_depth: expected %0d got %0d",
                   want.right_depth, result.right_depth);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the wall segment projection pipeline.
// ----------------------------------------------------------------------------
// Directed segments first (near plane, clipping, swap, off screen,
// saturation), then random walls under a range of camera settings, with
// sender idling in several phases. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG = 2000;
  localparam int DRAIN = 60;     // pipeline is 45 deep
  // index past the register map, must be ignored
  localparam logic [wsp_pkg::IDX_W-1:0] REG_UNMAPPED = wsp_pkg::IDX_W'(6);

  logic clk, rst, start, busy, done, cfg_write;
  wsp_pkg::seg_t seg;
  wsp_pkg::result_t result;
  logic [wsp_pkg::IDX_W-1:0] cfg_index;
  logic [wsp_pkg::CFG_W-1:0] cfg_data;
  int fail_count, pending;
  int idle_pct;
  int quiet_cycles;

  wall_segment_screen_projection uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .seg(seg),
    .done(done), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wsp_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .seg(seg),
    .done(done), .result(result), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no transaction of either kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // one segment transaction; start stays high when the next one follows
  task automatic send_segment(wsp_pkg::seg_t s);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    seg <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [wsp_pkg::IDX_W-1:0] idx, logic [wsp_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_camera(int px, int py, int c, int s, int vd, int sw);
    write_reg(wsp_pkg::REG_CAMERA_POS_X, px);
    write_reg(wsp_pkg::REG_CAMERA_POS_Y, py);
    write_reg(wsp_pkg::REG_ROT_COSINE, c);
    write_reg(wsp_pkg::REG_ROT_SINE, s);
    write_reg(wsp_pkg::REG_VIEW_DISTANCE, vd);
    write_reg(wsp_pkg::REG_SCREEN_WIDTH, sw);
  endtask

  function automatic wsp_pkg::seg_t mk(int sx, int sy, int ex, int ey);
    wsp_pkg::seg_t s;
    s.start_x = sx; s.start_y = sy; s.end_x = ex; s.end_y = ey;
    return s;
  endfunction

  // world coordinate: mostly near the camera, sometimes any 32-bit value
  function automatic int rand_coord(int center);
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return center + $urandom_range(7000) - 3500;
      default: return center + int'($urandom_range(32'h0060_0000)) - 32'sh0030_0000;
    endcase
  endfunction

  task automatic random_run(int count, int px, int py);
    repeat (count) begin
      send_segment(mk(rand_coord(px), rand_coord(py), rand_coord(px), rand_coord(py)));
    end
  endtask

  initial begin
    int px, py, c, s;
    rst = 1'b1;
    start = 1'b0;
    seg = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: depth along x
    send_segment(mk(6554, 0, 6554, 65536));          // both at near plane
    send_segment(mk(6553, 0, 6000, 65536));          // both behind
    send_segment(mk(65536, 0, 65536 * 4, 65536));    // plain visible
    send_segment(mk(0, -65536, 65536 * 2, 65536));   // first endpoint clipped
    send_segment(mk(65536 * 2, 65536, -100, -65536)); // second clipped
    send_segment(mk(6554, 65536, 65536, 0));         // one exactly at plane
    send_segment(mk(65536, 65536, 65536, -65536));   // swap needed
    send_segment(mk(65536, 0, 65536 * 3, 0));        // equal columns
    send_segment(mk(65536, 32'sh7FFF0000, 65536, 32'sh7FFFFFFF)); // saturate high
    send_segment(mk(65536, 32'sh80000000, 65536, -32'sh70000000)); // off left
    send_segment(mk(32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 1)); // far depth
    send_segment(mk(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_segment(mk(-1, -1, -1, -1));
    drain_pipe();

    // extremes of the registers
    set_camera(32'sh80000000, 32'sh7FFFFFFF, -16384, 16384, 4095, 4095);
    send_segment(mk(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_segment(mk(0, 0, 32'sh7FFFFFFF, 0));
    drain_pipe();
    set_camera(0, 0, 16384, 0, 0, 0);                 // view 0, width 0
    send_segment(mk(65536, 65536, 65536, -65536));
    send_segment(mk(65536, -65536, 65536 * 2, -65536 * 3));
    drain_pipe();
    set_camera(0, 0, 32'hFFFF_4000, 32'h0000_C000, 1, 1); // unnormalized
    send_segment(mk(65536, 0, 65536 * 5, 65536));
    send_segment(mk(-65536, 0, 65536, 65536));
    drain_pipe();

    // random phases under random cameras
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 21;
        default: idle_pct = 0;   // no idling; the design has no back-pressure, so results cannot be held off
      endcase
      px = (ph % 5 == 0) ? $urandom : int'($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
      py = (ph % 5 == 0) ? $urandom : int'($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
      case (ph % 4)
        0: begin c = 16384; s = 0; end
        1: begin c = 0; s = 16384; end
        2: begin c = $urandom_range(32768) - 16384; s = $urandom_range(32768) - 16384; end
        default: begin c = 11585; s = -11585; end
      endcase
      set_camera(px, py, (ph == 7) ? $urandom : c, (ph == 7) ? $urandom : s,
                 (ph == 9) ? $urandom : $urandom_range(4095, 1),
                 (ph == 11) ? $urandom : $urandom_range(4095, 1));
      if (ph == 5) write_reg(REG_UNMAPPED, $urandom);
      random_run(100, px, py);
      drain_pipe();                              // sender waits for all results
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/wsp_pkg.sv
sv/wsp_div.sv
sv/wsp_xform.sv
sv/wsp_interp.sv
sv/wall_segment_screen_projection.sv
test/wsp_checker.sv
test/tb_top.sv
